// ===== sv/ptfm_pkg.sv =====
// Shared codes, widths and types for the pipe table FIFO manager.
package ptfm_pkg;

   localparam int ID_W    = 16;
   localparam int BYTE_W  = 8;
   localparam int USERS_W = 8;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 3;

   localparam logic [USERS_W-1:0] USERS_MAX = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_OPEN  = 2'd0,
      FUNC_CLOSE = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_WRITE = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK     = 3'd0,
      STAT_NOPIPE = 3'd1,
      STAT_NOSLOT = 3'd2,
      STAT_EMPTY  = 3'd3,
      STAT_FULL   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DESC = 3'b010,
      ST_BYTE = 3'b100
   } state_type;

endpackage

// ===== sv/ptfm_ram.sv =====
// Simple dual-port synchronous RAM with registered read data.
module ptfm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/ptfm_slot_table.sv =====
// Slot table: valid bits and pipe ids in flops, id lookup and free-slot search.
module ptfm_slot_table #(
   parameter int NUM_PIPES = 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic [ptfm_pkg::ID_W-1:0]                     lookup_id,
   output logic                                          hit,
   output logic [(NUM_PIPES > 1 ? $clog2(NUM_PIPES) : 1)-1:0] hit_idx,
   output logic                                          free_ok,
   output logic [(NUM_PIPES > 1 ? $clog2(NUM_PIPES) : 1)-1:0] free_idx,
   input  logic                                          claim_en,
   input  logic [(NUM_PIPES > 1 ? $clog2(NUM_PIPES) : 1)-1:0] claim_idx,
   input  logic [ptfm_pkg::ID_W-1:0]                     claim_id,
   input  logic                                          release_en,
   input  logic [(NUM_PIPES > 1 ? $clog2(NUM_PIPES) : 1)-1:0] release_idx
);

   localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;

   logic [NUM_PIPES-1:0]      used_ff;
   logic [NUM_PIPES-1:0]      used_in;
   logic [ptfm_pkg::ID_W-1:0] ident_ff [NUM_PIPES];

   // lowest matching used slot and lowest free slot win
   always_comb begin
      hit      = 1'b0;
      hit_idx  = '0;
      free_ok  = 1'b0;
      free_idx = '0;
      for (int i = NUM_PIPES - 1; i >= 0; i--) begin
         if (used_ff[i] && (ident_ff[i] == lookup_id)) begin
            hit     = 1'b1;
            hit_idx = SLOT_W'(i);
         end
         if (!used_ff[i]) begin
            free_ok  = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      if (claim_en) begin
         used_in[claim_idx] = 1'b1;
      end
      if (release_en) begin
         used_in[release_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (claim_en) begin
         ident_ff[claim_idx] <= claim_id;
      end
   end

endmodule

// ===== sv/pipe_table_fifo_manager.sv =====
// Pipe table FIFO manager top level: control sequencer, descriptor RAM and byte RAM.
//
// One request beat is worked on at a time. A beat is taken while the block is idle,
// even when the previous response still waits at the output register. Open, close,
// write and failed reads go through slot lookup plus descriptor RAM read, then
// descriptor update; a successful read adds a byte RAM read before its response
// is loaded. Completion waits while the output register still holds an untaken response.
// Slot ids and valid bits sit in flops for a parallel id match; per-pipe user count,
// head, tail and fill level sit in a NUM_PIPES-entry descriptor RAM; the ring buffers
// share one NUM_PIPES*BUF_DEPTH byte RAM. No clearing pass is needed after reset.
module pipe_table_fifo_manager #(
   parameter int NUM_PIPES = 8,
   parameter int BUF_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // pipe_id[15:0], data_byte[23:16]
   input  logic [1:0]  req_tuser,   // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // status[2:0], read_data[10:3], users_now[18:11], zero
);

   localparam int SLOT_W = (NUM_PIPES > 1) ? $clog2(NUM_PIPES) : 1;
   localparam int PTR_W  = $clog2(BUF_DEPTH);
   localparam int FILL_W = $clog2(BUF_DEPTH + 1);
   localparam int MEM_DEPTH = NUM_PIPES * BUF_DEPTH;
   localparam int ADDR_W = $clog2(MEM_DEPTH);
   localparam int DESC_W = ptfm_pkg::USERS_W + 2 * PTR_W + FILL_W;

   typedef struct packed {
      logic [ptfm_pkg::USERS_W-1:0] users;
      logic [PTR_W-1:0]             head;
      logic [PTR_W-1:0]             tail;
      logic [FILL_W-1:0]            fill;
   } desc_type;

   ptfm_pkg::state_type state_ff, state_in;

   ptfm_pkg::func_type            func_ff;
   logic [ptfm_pkg::ID_W-1:0]     id_ff;
   logic [ptfm_pkg::BYTE_W-1:0]   data_ff;
   logic                          hit_ff;
   logic                          free_ok_ff;
   logic [SLOT_W-1:0]             slot_ff;

   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [23:0]                   rsp_tdata_ff;

   logic                          lk_hit, lk_free_ok;
   logic [SLOT_W-1:0]             lk_hit_idx, lk_free_idx;

   logic                          req_beat;
   logic                          out_free;
   logic                          go;
   logic                          is_pop;
   logic                          load_desc_rsp;
   logic                          load_byte_rsp;

   desc_type                      desc_rd;
   desc_type                      desc_new;
   logic                          desc_we_q;
   logic                          desc_rd_en;
   logic [SLOT_W-1:0]             desc_wr_addr;
   logic [DESC_W-1:0]             desc_rd_raw;

   logic                          claim_q, release_q;
   logic                          byte_we_q;
   logic [ADDR_W-1:0]             byte_base;
   logic [ADDR_W-1:0]             byte_wr_addr;
   logic [ADDR_W-1:0]             byte_rd_addr;
   logic [ptfm_pkg::BYTE_W-1:0]   byte_rd;

   ptfm_pkg::status_type          status_q;
   logic [ptfm_pkg::USERS_W-1:0]  users_q;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(BUF_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   assign req_tready = (state_ff == ptfm_pkg::ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   ptfm_slot_table #(
      .NUM_PIPES (NUM_PIPES)
   ) u_slot_table (
      .clock       (clock),
      .reset       (reset),
      .lookup_id   (req_tdata[15:0]),
      .hit         (lk_hit),
      .hit_idx     (lk_hit_idx),
      .free_ok     (lk_free_ok),
      .free_idx    (lk_free_idx),
      .claim_en    (claim_q && go),
      .claim_idx   (slot_ff),
      .claim_id    (id_ff),
      .release_en  (release_q && go),
      .release_idx (slot_ff)
   );

   // request capture and lookup result
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff    <= ptfm_pkg::func_type'(req_tuser);
         id_ff      <= req_tdata[15:0];
         data_ff    <= req_tdata[23:16];
         hit_ff     <= lk_hit;
         free_ok_ff <= lk_free_ok;
         slot_ff    <= lk_hit ? lk_hit_idx : lk_free_idx;
      end
   end

   assign desc_rd_en   = req_beat;
   assign desc_wr_addr = slot_ff;
   assign desc_rd      = desc_type'(desc_rd_raw);

   ptfm_ram #(
      .WIDTH (DESC_W),
      .DEPTH (NUM_PIPES)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we_q && go),
      .wr_addr (desc_wr_addr),
      .wr_data (DESC_W'(desc_new)),
      .rd_en   (desc_rd_en),
      .rd_addr (lk_hit_idx),
      .rd_data (desc_rd_raw)
   );

   assign byte_base    = ADDR_W'(slot_ff) * ADDR_W'(BUF_DEPTH);
   assign byte_wr_addr = byte_base + ADDR_W'(desc_rd.tail);
   assign byte_rd_addr = byte_base + ADDR_W'(desc_rd.head);

   ptfm_ram #(
      .WIDTH (ptfm_pkg::BYTE_W),
      .DEPTH (MEM_DEPTH)
   ) u_byte_ram (
      .clock   (clock),
      .wr_en   (byte_we_q && go),
      .wr_addr (byte_wr_addr),
      .wr_data (data_ff),
      .rd_en   (is_pop && (state_ff == ptfm_pkg::ST_DESC)),
      .rd_addr (byte_rd_addr),
      .rd_data (byte_rd)
   );

   // descriptor update; writes qualified by go
   always_comb begin
      desc_new  = desc_rd;
      desc_we_q = 1'b0;
      claim_q   = 1'b0;
      release_q = 1'b0;
      byte_we_q = 1'b0;
      is_pop    = 1'b0;
      status_q  = ptfm_pkg::STAT_OK;
      users_q   = '0;
      case (func_ff)
         ptfm_pkg::FUNC_OPEN: begin
            if (hit_ff) begin
               if (desc_rd.users != ptfm_pkg::USERS_MAX) begin
                  desc_new.users = desc_rd.users + ptfm_pkg::USERS_W'(1);
               end
               desc_we_q = 1'b1;
               users_q   = desc_new.users;
            end else if (free_ok_ff) begin
               desc_new.users = ptfm_pkg::USERS_W'(1);
               desc_new.head  = '0;
               desc_new.tail  = '0;
               desc_new.fill  = '0;
               desc_we_q = 1'b1;
               claim_q   = 1'b1;
               users_q   = ptfm_pkg::USERS_W'(1);
            end else begin
               status_q = ptfm_pkg::STAT_NOSLOT;
            end
         end
         ptfm_pkg::FUNC_CLOSE: begin
            if (!hit_ff) begin
               status_q = ptfm_pkg::STAT_NOPIPE;
            end else begin
               if (desc_rd.users != '0) begin
                  desc_new.users = desc_rd.users - ptfm_pkg::USERS_W'(1);
               end
               desc_we_q = 1'b1;
               release_q = (desc_new.users == '0);
               users_q   = desc_new.users;
            end
         end
         ptfm_pkg::FUNC_READ: begin
            if (!hit_ff) begin
               status_q = ptfm_pkg::STAT_NOPIPE;
            end else if (desc_rd.fill == '0) begin
               status_q = ptfm_pkg::STAT_EMPTY;
            end else begin
               desc_new.head = ptr_next(desc_rd.head);
               desc_new.fill = desc_rd.fill - FILL_W'(1);
               desc_we_q = 1'b1;
               is_pop    = 1'b1;
            end
         end
         ptfm_pkg::FUNC_WRITE: begin
            if (!hit_ff) begin
               status_q = ptfm_pkg::STAT_NOPIPE;
            end else if (desc_rd.fill == FILL_W'(BUF_DEPTH)) begin
               status_q = ptfm_pkg::STAT_FULL;
            end else begin
               desc_new.tail = ptr_next(desc_rd.tail);
               desc_new.fill = desc_rd.fill + FILL_W'(1);
               desc_we_q = 1'b1;
               byte_we_q = 1'b1;
            end
         end
         default: begin
            status_q = ptfm_pkg::STAT_OK;
         end
      endcase
   end

   // a pop moves on to the byte read; everything else finishes into the output register
   assign go = (state_ff == ptfm_pkg::ST_DESC) && (is_pop || out_free);
   assign load_desc_rsp = go && !is_pop;
   assign load_byte_rsp = (state_ff == ptfm_pkg::ST_BYTE) && out_free;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ptfm_pkg::ST_IDLE: begin
            if (req_beat) begin
               state_in = ptfm_pkg::ST_DESC;
            end
         end
         ptfm_pkg::ST_DESC: begin
            if (go) begin
               state_in = is_pop ? ptfm_pkg::ST_BYTE : ptfm_pkg::ST_IDLE;
            end
         end
         ptfm_pkg::ST_BYTE: begin
            if (out_free) begin
               state_in = ptfm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptfm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptfm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (load_desc_rsp || load_byte_rsp) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_desc_rsp) begin
         rsp_tdata_ff <= {5'd0, users_q, {ptfm_pkg::BYTE_W{1'b0}}, status_q};
      end else if (load_byte_rsp) begin
         rsp_tdata_ff <= {5'd0, {ptfm_pkg::USERS_W{1'b0}}, byte_rd, ptfm_pkg::STAT_OK};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef ASSERT_OFF
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while an item is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && rsp_tvalid))
      else $error("pending response overwritten");

   a_claim_release: assert property (@(posedge clock) disable iff (reset)
      !(claim_q && release_q))
      else $error("slot claimed and released together");

   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[2:0] != ptfm_pkg::STAT_OK)) |->
         (rsp_tdata[18:3] == '0))
      else $error("failed request carries nonzero payload");
`endif

endmodule
